// ===== sv/mcf_pkg.sv =====
// ----------------------------------------------------------------------------
// mcf_pkg
// Shared types, constants and byte/CRC functions for the motor command framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcf_pkg;

   localparam int FrameLen     = 30;
   localparam int CrcBytes     = 24;
   localparam int CountWidth   = $clog2(FrameLen);

   localparam logic [CountWidth-1:0] LastIndex = CountWidth'(FrameLen - 1);
   localparam logic [CountWidth-1:0] CrcLimit  = CountWidth'(CrcBytes);

   localparam logic [31:0] FrameMagic = 32'hDEADBEEF;
   localparam logic [31:0] CrcPoly    = 32'h04C11DB7;
   localparam logic [31:0] CrcInit    = 32'hFFFFFFFF;

   typedef struct packed {
      logic [15:0] node_id;
      logic [31:0] position_bits;
      logic [31:0] velocity_bits;
      logic [31:0] stiffness_bits;
      logic [31:0] damping_bits;
      logic [31:0] torque_bits;
   } mcf_req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
   } mcf_rsp_type;

   typedef struct packed {
      logic        valid;
      mcf_req_type cmd;
   } mcf_handoff_type;

   // Frame byte at wire offset idx; offsets 26 to 29 take the CRC, offsets past 29 give zero.
   function automatic logic [7:0] frame_byte_at(mcf_req_type cmd, logic [31:0] crc,
                                                logic [CountWidth-1:0] idx);
      logic [7:0] b;
      case (idx)
         5'd0:    b = FrameMagic[7:0];
         5'd1:    b = FrameMagic[15:8];
         5'd2:    b = FrameMagic[23:16];
         5'd3:    b = FrameMagic[31:24];
         5'd4:    b = cmd.node_id[7:0];
         5'd5:    b = cmd.node_id[15:8];
         5'd6:    b = cmd.position_bits[7:0];
         5'd7:    b = cmd.position_bits[15:8];
         5'd8:    b = cmd.position_bits[23:16];
         5'd9:    b = cmd.position_bits[31:24];
         5'd10:   b = cmd.velocity_bits[7:0];
         5'd11:   b = cmd.velocity_bits[15:8];
         5'd12:   b = cmd.velocity_bits[23:16];
         5'd13:   b = cmd.velocity_bits[31:24];
         5'd14:   b = cmd.stiffness_bits[7:0];
         5'd15:   b = cmd.stiffness_bits[15:8];
         5'd16:   b = cmd.stiffness_bits[23:16];
         5'd17:   b = cmd.stiffness_bits[31:24];
         5'd18:   b = cmd.damping_bits[7:0];
         5'd19:   b = cmd.damping_bits[15:8];
         5'd20:   b = cmd.damping_bits[23:16];
         5'd21:   b = cmd.damping_bits[31:24];
         5'd22:   b = cmd.torque_bits[7:0];
         5'd23:   b = cmd.torque_bits[15:8];
         5'd24:   b = cmd.torque_bits[23:16];
         5'd25:   b = cmd.torque_bits[31:24];
         5'd26:   b = crc[7:0];
         5'd27:   b = crc[15:8];
         5'd28:   b = crc[23:16];
         5'd29:   b = crc[31:24];
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Advance the CRC by eight bits, most significant bit first.
   function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] data);
      logic [31:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[31] ^ data[i];
         c  = {c[30:0], 1'b0} ^ (fb ? CrcPoly : 32'h0);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== sv/mcf_input_stage.sv =====
// ----------------------------------------------------------------------------
// mcf_input_stage
// Command holding register; takes a new command while empty, or as soon as
// the serializer takes the held one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcf_input_stage
   import mcf_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_stall,
   input  wire mcf_req_type     req_data,
   input  wire logic            take,
   output      mcf_handoff_type handoff
);

   logic        hold_valid_ff;
   logic        hold_valid_in;
   mcf_req_type cmd_ff;
   logic        accept;

   assign req_stall = hold_valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (take) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_data;
      end
   end

   assign handoff.valid = hold_valid_ff;
   assign handoff.cmd   = cmd_ff;

endmodule

`default_nettype wire

// ===== sv/mcf_serializer.sv =====
// ----------------------------------------------------------------------------
// mcf_serializer
// Byte sequencer with running CRC and result register; one frame byte per
// transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcf_serializer
   import mcf_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire mcf_handoff_type handoff,
   output      logic            take,
   output      logic            rsp_valid,
   input  wire logic            rsp_stall,
   output      mcf_rsp_type     rsp_data
);

   logic                  busy_ff,      busy_in;
   logic [CountWidth-1:0] cnt_ff,       cnt_in;
   logic [31:0]           crc_ff,       crc_in;
   mcf_req_type           cmd_ff,       cmd_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mcf_rsp_type           rsp_ff,       rsp_in;

   logic                  advance;
   logic                  step;
   logic                  last;
   logic [CountWidth-1:0] crc_idx;
   logic [7:0]            crc_data;

   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign step     = busy_ff && advance;
   assign last     = step && (cnt_ff == LastIndex);
   assign take     = handoff.valid && (!busy_ff || last);
   // Each aligned group of four bytes goes into the CRC most significant byte first.
   assign crc_idx  = {cnt_ff[CountWidth-1:2], ~cnt_ff[1:0]};
   assign crc_data = frame_byte_at(cmd_ff, crc_ff, crc_idx);

   always_comb begin
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      crc_in       = crc_ff;
      cmd_in       = cmd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (step) begin
         rsp_valid_in        = 1'b1;
         rsp_in.frame_byte   = frame_byte_at(cmd_ff, crc_ff, cnt_ff);
         rsp_in.frame_end    = (cnt_ff == LastIndex);
         cnt_in              = cnt_ff + 1'b1;
         if (cnt_ff < CrcLimit) begin
            crc_in = crc_byte(crc_ff, crc_data);
         end
         if (last) begin
            busy_in = 1'b0;
         end
      end else if (advance) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         crc_in  = CrcInit;
         cmd_in  = handoff.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      crc_ff <= crc_in;
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== sv/motor_command_framer_crc32_core.sv =====
// A command passes the holding register and the sequencer before its first frame byte is on rsp.
// One frame byte per cycle while rsp_stall is low; the byte
// sequencer sets the rate and takes the next command on its last byte.
// A one-deep holding register takes a command while a frame is streaming.
// Reset (synchronous, active high) empties the holding register, the
// sequencer and the result register.
// ----------------------------------------------------------------------------
// motor_command_framer_crc32_core
// Packs a motor command into a 30-byte frame with header and CRC-32.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module motor_command_framer_crc32_core
   import mcf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire mcf_req_type req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      mcf_rsp_type rsp_data
);

   mcf_handoff_type handoff;
   logic            take;

   mcf_input_stage u_input_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .take      (take),
      .handoff   (handoff)
   );

   mcf_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .handoff   (handoff),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sv/mcf_checker.sv =====
// ----------------------------------------------------------------------------
// mcf_checker
// Port-level checks on the framer: frame boundaries, result hold under stall and reset behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcf_checker
   import mcf_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire mcf_rsp_type rsp_data
);

   logic [CountWidth-1:0] seen_ff;
   logic [CountWidth-1:0] seen_in;
   logic                  rsp_xfer;
   logic                  req_xfer;

   assign rsp_xfer = rsp_valid && !rsp_stall;
   assign req_xfer = req_valid && !req_stall;

   always_comb begin
      seen_in = seen_ff;
      if (rsp_xfer) begin
         seen_in = (seen_ff == LastIndex) ? '0 : seen_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   a_end_on_thirtieth: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer |-> (rsp_data.frame_end == (seen_ff == LastIndex)))
      else $error("frame_end out of place");

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_req_open_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_stall)
      else $error("command stalled right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   a_no_bytes_without_command: assert property (@(posedge clock) disable iff (reset)
      ($past(reset) && !req_xfer) |=> !rsp_valid)
      else $error("result without a command");

endmodule

bind motor_command_framer_crc32_core mcf_checker u_mcf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
